@@ rtl/csu_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csu_pkg
// Shared types and constants of the cosine similarity unit.
// ---------------------------------------------------------------------------
package csu_pkg;

    localparam int ACC_W      = 44;   // accumulator width, units of 2^-30
    localparam int ELEM_W     = 16;   // Q1.15 element width
    localparam int PROD_W     = 32;   // exact product width
    localparam int WIDE_W     = 64;   // sqrt operand, denominator, numerator
    localparam int ROOT_W     = 32;   // square root result width
    localparam int QUOT_W     = 17;   // quotient bits before rounding
    localparam int RES_W      = 17;   // Q2.15 result width
    localparam int FLOOR_W    = 21;   // denominator floor width
    localparam int IDX_W      = 8;    // config register index width
    localparam int STEP_W     = 5;    // step counter width
    localparam int SQRT_STEPS = 32;   // one result bit per step
    localparam int DIV_STEPS  = 16;   // fraction bits after the integer bit
    localparam int SHIFT_IN   = 20;   // pre-shift of norms and dot

    localparam logic [IDX_W-1:0] REG_METRIC_MODE = 8'd0;
    localparam logic [IDX_W-1:0] REG_DENOM_FLOOR = 8'd1;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_LOAD_A,
        ST_SQRT_A,
        ST_LOAD_B,
        ST_SQRT_B,
        ST_MUL,
        ST_CHECK,
        ST_DIV
    } csu_state_t;

    // controller to datapath
    typedef struct packed {
        logic acc_en;     // add the accepted pair into the sums
        logic sq_load;    // load square root operand
        logic sq_sel_b;   // operand select: 0 norm a, 1 norm b
        logic sq_step;    // one square root iteration
        logic sa_store;   // keep root of norm a
        logic mul_en;     // form denominator and numerator
        logic div_init;   // first quotient bit and overflow check
        logic div_step;   // one fraction bit
        logic out_load;   // load result register and clear sums
    } csu_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic degen;      // denominator below floor or zero
    } csu_status_t;

endpackage

@@ rtl/csu_datapath.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csu_datapath
// Accumulators, shared iterative square root, denominator multiply and
// serial divider with rounding and metric selection.
// ---------------------------------------------------------------------------
module csu_datapath #(
    parameter int MAX_DIM = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  csu_pkg::csu_cmd_t              cmd,
    output csu_pkg::csu_status_t           status,
    input  logic signed [csu_pkg::ELEM_W-1:0] elem_a,
    input  logic signed [csu_pkg::ELEM_W-1:0] elem_b,
    input  logic                           metric_mode,
    input  logic [csu_pkg::FLOOR_W-1:0]    denom_floor,
    output logic [csu_pkg::RES_W-1:0]      result_value,
    output logic                           degenerate
);
    import csu_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIM + 1);

    logic signed [ACC_W-1:0] dot_reg, dot_next;
    logic signed [ACC_W-1:0] na_reg, na_next;
    logic signed [ACC_W-1:0] nb_reg, nb_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;

    logic [WIDE_W-1:0] sq_x_reg, sq_res_reg, sq_bit_reg;
    logic [WIDE_W-1:0] sq_x_next, sq_res_next, sq_bit_next;
    logic [WIDE_W-1:0] sq_trial;
    logic [ROOT_W-1:0] sa_reg;

    logic [WIDE_W-1:0] denom_reg;
    logic [WIDE_W-1:0] num_reg;
    logic              neg_reg;
    logic [WIDE_W-1:0] rem_reg, rem_next;
    logic [QUOT_W-1:0] quo_reg, quo_next;
    logic              cap_reg;
    logic [WIDE_W:0]   rem_dbl;

    logic [RES_W-1:0]  result_reg;
    logic              degen_reg;

    logic signed [PROD_W-1:0] p_ab, p_aa, p_bb;
    logic [ACC_W-1:0]         dot_abs;
    logic [QUOT_W:0]          rnd;
    logic [ELEM_W-1:0]        mag;
    logic signed [RES_W:0]    sim;
    logic signed [RES_W:0]    dist_val;
    logic signed [RES_W:0]    val;
    logic                     degen;

    // saturating add into the signed accumulator range
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0]  acc,
        input logic signed [PROD_W-1:0] p
    );
        logic signed [ACC_W:0] s;
        s = {acc[ACC_W-1], acc} + {{(ACC_W-PROD_W+1){p[PROD_W-1]}}, p};
        if (s[ACC_W] != s[ACC_W-1])
            sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        else
            sat_add = s[ACC_W-1:0];
    endfunction

    // element products
    assign p_ab = elem_a * elem_b;
    assign p_aa = elem_a * elem_a;
    assign p_bb = elem_b * elem_b;

    // accumulator update, cleared on result load, frozen past the dimension limit
    always_comb
    begin
        dot_next = dot_reg;
        na_next  = na_reg;
        nb_next  = nb_reg;
        cnt_next = cnt_reg;
        if (cmd.out_load)
        begin
            dot_next = '0;
            na_next  = '0;
            nb_next  = '0;
            cnt_next = '0;
        end
        else if (cmd.acc_en && (cnt_reg < CNT_W'(MAX_DIM)))
        begin
            dot_next = sat_add(dot_reg, p_ab);
            na_next  = sat_add(na_reg, p_aa);
            nb_next  = sat_add(nb_reg, p_bb);
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg <= '0;
            na_reg  <= '0;
            nb_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            dot_reg <= dot_next;
            na_reg  <= na_next;
            nb_reg  <= nb_next;
            cnt_reg <= cnt_next;
        end
    end

    // bit-by-bit integer square root, one result bit per step
    assign sq_trial = sq_res_reg + sq_bit_reg;

    always_comb
    begin
        sq_x_next   = sq_x_reg;
        sq_res_next = sq_res_reg;
        sq_bit_next = sq_bit_reg;
        if (cmd.sq_load)
        begin
            sq_x_next   = cmd.sq_sel_b ? {nb_reg, {SHIFT_IN{1'b0}}}
                                       : {na_reg, {SHIFT_IN{1'b0}}};
            sq_res_next = '0;
            sq_bit_next = {2'b01, {(WIDE_W-2){1'b0}}};
        end
        else if (cmd.sq_step)
        begin
            if (sq_x_reg >= sq_trial)
            begin
                sq_x_next   = sq_x_reg - sq_trial;
                sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
            end
            else
                sq_res_next = sq_res_reg >> 1;
            sq_bit_next = sq_bit_reg >> 2;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_x_reg   <= sq_x_next;
        sq_res_reg <= sq_res_next;
        sq_bit_reg <= sq_bit_next;
        if (cmd.sa_store)
            sa_reg <= sq_res_reg[ROOT_W-1:0];
    end

    // denominator product and numerator magnitude
    assign dot_abs = dot_reg[ACC_W-1] ? (~dot_reg + 1'b1) : dot_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            denom_reg <= sa_reg * sq_res_reg[ROOT_W-1:0];
            num_reg   <= {dot_abs, {SHIFT_IN{1'b0}}};
            neg_reg   <= dot_reg[ACC_W-1];
        end
    end

    // degenerate denominator
    assign degen = (denom_reg == '0) ||
                   (denom_reg < {{(WIDE_W-FLOOR_W-SHIFT_IN){1'b0}}, denom_floor,
                                 {SHIFT_IN{1'b0}}});
    assign status.degen = degen;

    // restoring division, one quotient bit per step
    assign rem_dbl = {rem_reg, 1'b0};

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (cmd.div_init)
        begin
            if (num_reg >= denom_reg)
            begin
                rem_next = num_reg - denom_reg;
                quo_next = QUOT_W'(1);
            end
            else
            begin
                rem_next = num_reg;
                quo_next = '0;
            end
        end
        else if (cmd.div_step)
        begin
            if (rem_dbl >= {1'b0, denom_reg})
            begin
                rem_next = WIDE_W'(rem_dbl - {1'b0, denom_reg});
                quo_next = {quo_reg[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_dbl[WIDE_W-1:0];
                quo_next = {quo_reg[QUOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (cmd.div_init)
            cap_reg <= ({1'b0, num_reg} >= {denom_reg, 1'b0});
    end

    // round to nearest, cap, sign and metric select
    assign rnd  = ({1'b0, quo_reg} + 1'b1) >> 1;
    assign mag  = (cap_reg || rnd[QUOT_W:ELEM_W] != '0) ? {ELEM_W{1'b1}}
                                                        : rnd[ELEM_W-1:0];
    assign sim  = degen ? '0
                : neg_reg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    assign dist_val = $signed((RES_W+1)'(32768)) - sim;

    always_comb
    begin
        if (!metric_mode)
            val = sim;
        else if (dist_val > $signed((RES_W+1)'(65535)))
            val = (RES_W+1)'(65535);
        else
            val = dist_val;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result_reg <= val[RES_W-1:0];
            degen_reg  <= degen;
        end
    end

    assign result_value = result_reg;
    assign degenerate   = degen_reg;

endmodule

@@ rtl/csu_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csu_ctrl
// Sequencer: accumulation, two square roots, multiply, divide and the
// output register handshake.
// ---------------------------------------------------------------------------
module csu_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_last,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  csu_pkg::csu_status_t status,
    output csu_pkg::csu_cmd_t    cmd
);
    import csu_pkg::*;

    csu_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_free;
    logic              in_req;

    assign out_free = !out_valid_reg || out_ready;
    assign in_req   = in_valid && (state_reg == ST_ACCUM);

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_ACCUM:
                if (in_valid && in_last)
                    state_next = ST_LOAD_A;
            ST_LOAD_A:
            begin
                state_next = ST_SQRT_A;
                step_next  = '0;
            end
            ST_SQRT_A:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                    state_next = ST_LOAD_B;
            end
            ST_LOAD_B:
            begin
                state_next = ST_SQRT_B;
                step_next  = '0;
            end
            ST_SQRT_B:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                    state_next = ST_MUL;
            end
            ST_MUL:
                state_next = ST_CHECK;
            ST_CHECK:
            begin
                step_next = '0;
                if (status.degen && out_free)
                    state_next = ST_ACCUM;
                else if (!status.degen)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (step_reg != STEP_W'(DIV_STEPS))
                    step_next = step_reg + 1'b1;
                else if (out_free)
                    state_next = ST_ACCUM;
            end
            default:
                state_next = ST_ACCUM;
        endcase
    end

    // commands
    always_comb
    begin
        cmd          = '0;
        cmd.acc_en   = in_req;
        cmd.sq_load  = (state_reg == ST_LOAD_A) || (state_reg == ST_LOAD_B);
        cmd.sq_sel_b = (state_reg == ST_LOAD_B);
        cmd.sq_step  = (state_reg == ST_SQRT_A) || (state_reg == ST_SQRT_B);
        cmd.sa_store = (state_reg == ST_LOAD_B);
        cmd.mul_en   = (state_reg == ST_MUL);
        cmd.div_init = (state_reg == ST_CHECK) && !status.degen;
        cmd.div_step = (state_reg == ST_DIV) && (step_reg != STEP_W'(DIV_STEPS));
        cmd.out_load = out_free &&
                       (((state_reg == ST_CHECK) && status.degen) ||
                        ((state_reg == ST_DIV) && (step_reg == STEP_W'(DIV_STEPS))));
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_ACCUM);
    assign out_valid = out_valid_reg;

    // a result is only loaded into a free output register
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending result");

    // accumulation continues until a last pair arrives
    a_stay_accum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACCUM && !(in_valid && in_last)) |=> state_reg == ST_ACCUM)
        else $error("left accumulation without a last pair");

    // a pending result stays valid until taken
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("pending result dropped");

    // no input taken while a vector is being finished
    a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_ACCUM) |-> !cmd.acc_en)
        else $error("pair accepted outside accumulation");

endmodule

@@ rtl/cosine_similarity_unit_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cosine_similarity_unit_core
// Streaming cosine similarity / distance of two Q1.15 vectors.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one element pair per request; tlast marks the final pair.
//   Pairs are taken one per cycle while a vector is being accumulated.
//   On the last pair the unit computes dot / sqrt(|a|^2 * |b|^2) and sends
//   one result on m_axis: tdata holds the Q2.15 value, tuser the flag that
//   the denominator fell below denom_floor (similarity then forced to 0).
//   The cfg channel writes metric_mode (index 0) and denom_floor (index 1);
//   it is always ready and is meant to be written while the unit is idle.
// Sequence:
//   after the last pair s_axis_tready is low while the unit runs two
//   32-step square roots on one shared unit with a load step each, one
//   multiply, one floor check, then 16 division steps and a step that
//   loads the result (when degenerate, the division is skipped and the
//   result is loaded at the floor check); m_axis_tvalid then rises.
// Stall: the result register holds while m_axis_tready is low; the next
//   vector is accumulated meanwhile, and a further result waits, with
//   s_axis_tready low, for the register to empty.
// Reset: sums cleared, metric_mode = 0, denom_floor = 1, no result pending.
// Pairs beyond MAX_DIM in one vector are not added to the sums.
// ---------------------------------------------------------------------------
module cosine_similarity_unit_core #(
    parameter int MAX_DIM = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    // elem_a [15:0], elem_b [31:16]
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // result_value [16:0], zero fill [23:17]
    output logic [23:0] m_axis_tdata,
    // degenerate [0]
    output logic [0:0]  m_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [20:0] cfg_data
);
    import csu_pkg::*;

    csu_cmd_t               cmd;
    csu_status_t            status;
    logic                   metric_mode_reg;
    logic [FLOOR_W-1:0]     denom_floor_reg;
    logic [RES_W-1:0]       result_value;
    logic                   degenerate;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_mode_reg <= 1'b0;
            denom_floor_reg <= FLOOR_W'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_METRIC_MODE: metric_mode_reg <= cfg_data[0];
                REG_DENOM_FLOOR: denom_floor_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    csu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    csu_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .elem_a       (s_axis_tdata[15:0]),
        .elem_b       (s_axis_tdata[31:16]),
        .metric_mode  (metric_mode_reg),
        .denom_floor  (denom_floor_reg),
        .result_value (result_value),
        .degenerate   (degenerate)
    );

    // output packing
    assign m_axis_tdata = {7'd0, result_value};
    assign m_axis_tuser = degenerate;

endmodule
